// ===== rtl/gcd_pkg.sv =====
// Shared constants and controller/datapath interface types for the change dispenser.
package gcd_pkg;

   // Denomination registers and field widths
   localparam int NREG    = 4;
   localparam int DENOM_W = 16;
   localparam int COUNT_W = 16;
   localparam int SLOT_FW = 2;

   // Request codes
   localparam logic REQ_REFILL = 1'b0;
   localparam logic REQ_CHANGE = 1'b1;

   // Denomination values after reset
   localparam logic [DENOM_W-1:0] DENOM_RESET [NREG] = '{16'd1, 16'd2, 16'd5, 16'd10};

   // Controller to datapath
   typedef struct packed {
      logic start;   // item accepted this cycle
      logic pay;     // take one coin this cycle if one fits
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic found;   // a coin fits the remaining amount
      logic done;    // taking that coin pays the amount exactly
   } dp_sts_type;

endpackage

// ===== rtl/gcd_datapath.sv =====
// Datapath: denomination registers, stock and usage counters, coin selection.
module gcd_datapath #(
   parameter int SLOT_CNT = 4,
   parameter int SLOT_W   = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [gcd_pkg::DENOM_W-1:0] csr_wdata,
   input  gcd_pkg::dp_cmd_type         cmd,
   output gcd_pkg::dp_sts_type         sts,
   input  logic                        req_type,
   input  logic [gcd_pkg::SLOT_FW-1:0] req_slot,
   input  logic [gcd_pkg::COUNT_W-1:0] req_refill_count,
   input  logic [gcd_pkg::DENOM_W-1:0] req_amount,
   input  logic [SLOT_W-1:0]           emit_idx,
   output logic [gcd_pkg::SLOT_FW-1:0] rsp_out_slot,
   output logic [gcd_pkg::COUNT_W-1:0] rsp_coins_used,
   output logic [gcd_pkg::COUNT_W-1:0] rsp_stock_left,
   output logic                        rsp_success
);
   import gcd_pkg::*;

   logic [DENOM_W-1:0] denom_ff     [NREG];
   logic [COUNT_W-1:0] stock_ff     [SLOT_CNT];
   logic [COUNT_W-1:0] used_ff      [SLOT_CNT];
   logic [DENOM_W-1:0] remaining_ff;
   logic               success_ff;

   logic [SLOT_W-1:0]  pick;
   logic [DENOM_W-1:0] best;
   logic               found;
   logic [DENOM_W-1:0] rem_after;

   // Coin selection: largest fitting denomination in stock, lowest slot on ties
   always_comb begin
      best  = '0;
      pick  = '0;
      found = 1'b0;
      for (int i = 0; i < SLOT_CNT; i++) begin
         if (denom_ff[i] > best && denom_ff[i] <= remaining_ff && stock_ff[i] != '0) begin
            best  = denom_ff[i];
            pick  = SLOT_W'(i);
            found = 1'b1;
         end
      end
      rem_after = remaining_ff - best;
   end

   assign sts.found = found;
   assign sts.done  = found && (rem_after == '0);

   // Denomination registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NREG; i++) begin
            denom_ff[i] <= DENOM_RESET[i];
         end
      end else if (csr_we) begin
         denom_ff[csr_index] <= csr_wdata;
      end
   end

   // Stock, usage and remaining amount
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_CNT; i++) begin
            stock_ff[i] <= '0;
            used_ff[i]  <= '0;
         end
         remaining_ff <= '0;
         success_ff   <= 1'b0;
      end else if (cmd.start) begin
         for (int i = 0; i < SLOT_CNT; i++) begin
            used_ff[i] <= '0;
         end
         if (req_type == REQ_REFILL) begin
            if (32'(req_slot) < SLOT_CNT) begin
               stock_ff[req_slot[SLOT_W-1:0]] <= req_refill_count;
            end
            success_ff <= 1'b1;
         end else begin
            remaining_ff <= req_amount;
         end
      end else if (cmd.pay) begin
         if (found) begin
            stock_ff[pick] <= stock_ff[pick] - COUNT_W'(1);
            used_ff[pick]  <= used_ff[pick] + COUNT_W'(1);
            remaining_ff   <= rem_after;
            if (rem_after == '0) begin
               success_ff <= 1'b1;
            end
         end else begin
            success_ff <= 1'b0;
         end
      end
   end

   // Result fields for the slot being reported
   assign rsp_out_slot   = SLOT_FW'(emit_idx);
   assign rsp_coins_used = used_ff[emit_idx];
   assign rsp_stock_left = stock_ff[emit_idx];
   assign rsp_success    = success_ff;

endmodule

// ===== rtl/gcd_ctrl.sv =====
// Controller: accepts an item, runs the payout loop for a change item, then sequences the per-slot results.
module gcd_ctrl #(
   parameter int SLOT_CNT = 4,
   parameter int SLOT_W   = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_last,
   output gcd_pkg::dp_cmd_type cmd,
   input  gcd_pkg::dp_sts_type sts,
   output logic [SLOT_W-1:0]   emit_idx
);
   import gcd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAY,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic              req_ready_ff;
   logic              rsp_valid_ff;
   logic [SLOT_W-1:0] emit_idx_ff;
   logic              last_slot;

   assign last_slot = (emit_idx_ff == SLOT_W'(SLOT_CNT - 1));

   assign cmd.start = req_valid && req_ready_ff;
   assign cmd.pay   = (state_ff == ST_PAY);

   // State and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         emit_idx_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  req_ready_ff <= 1'b0;
                  emit_idx_ff  <= '0;
                  if (req_type == REQ_CHANGE) begin
                     state_ff <= ST_PAY;
                  end else begin
                     state_ff     <= ST_EMIT;
                     rsp_valid_ff <= 1'b1;
                  end
               end else begin
                  // input opens in the cycle after reset is released
                  req_ready_ff <= 1'b1;
               end
            end
            ST_PAY: begin
               // one coin per cycle until paid or nothing fits
               if (!sts.found || sts.done) begin
                  state_ff     <= ST_EMIT;
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_EMIT: begin
               if (rsp_ready) begin
                  if (last_slot) begin
                     state_ff     <= ST_IDLE;
                     rsp_valid_ff <= 1'b0;
                     req_ready_ff <= 1'b1;
                  end else begin
                     emit_idx_ff <= emit_idx_ff + SLOT_W'(1);
                  end
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_last  = last_slot;
   assign emit_idx  = emit_idx_ff;

endmodule

// ===== rtl/greedy_change_dispenser.sv =====
// Top level of the greedy coin change dispenser with limited stock per slot.
//
//  Channel | Direction | Handshake             | Contents
//  req     | in        | req_valid / req_ready | type, slot, refill count, amount
//  rsp     | out       | rsp_valid / rsp_ready | one item per slot: usage, stock, success, last
//  csr     | in        | csr_we                | denomination register writes
//
// A refill item is accepted, then one result per slot is reported.
// A change item is accepted, then the coin loop runs until the amount is paid
// or no coin fits, then one result per slot is reported; the coin loop selects
// and removes a single coin each cycle. Reset clears all stock, restores the
// default denominations and keeps the input closed; it opens in the cycle after
// reset falls. Result stalls hold the block; no new item is taken until the
// last result of the item is taken.
module greedy_change_dispenser #(
   parameter int DENOM_SLOTS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_type,
   input  logic [gcd_pkg::SLOT_FW-1:0] req_slot,
   input  logic [gcd_pkg::COUNT_W-1:0] req_refill_count,
   input  logic [gcd_pkg::DENOM_W-1:0] req_amount,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [gcd_pkg::SLOT_FW-1:0] rsp_out_slot,
   output logic [gcd_pkg::COUNT_W-1:0] rsp_coins_used,
   output logic [gcd_pkg::COUNT_W-1:0] rsp_stock_left,
   output logic                        rsp_success,
   output logic                        rsp_last,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [gcd_pkg::DENOM_W-1:0] csr_wdata
);
   import gcd_pkg::*;

   // Only as many slots as there are denomination registers
   localparam int SLOT_CNT = (DENOM_SLOTS < NREG) ? DENOM_SLOTS : NREG;
   localparam int SLOT_W   = (SLOT_CNT > 1) ? $clog2(SLOT_CNT) : 1;

   dp_cmd_type        cmd;
   dp_sts_type        sts;
   logic [SLOT_W-1:0] emit_idx;

   gcd_ctrl #(
      .SLOT_CNT (SLOT_CNT),
      .SLOT_W   (SLOT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_last  (rsp_last),
      .cmd       (cmd),
      .sts       (sts),
      .emit_idx  (emit_idx)
   );

   gcd_datapath #(
      .SLOT_CNT (SLOT_CNT),
      .SLOT_W   (SLOT_W)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .sts              (sts),
      .req_type         (req_type),
      .req_slot         (req_slot),
      .req_refill_count (req_refill_count),
      .req_amount       (req_amount),
      .emit_idx         (emit_idx),
      .rsp_out_slot     (rsp_out_slot),
      .rsp_coins_used   (rsp_coins_used),
      .rsp_stock_left   (rsp_stock_left),
      .rsp_success      (rsp_success)
   );

   // Never ready for a new item while results are being reported
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("req_ready high while results pending");

   // An accepted item closes the input until its results are done
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input still open after accept");

   // Taking the last result reopens the input
   a_last_reopens: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> (req_ready && !rsp_valid))
      else $error("input not reopened after last result");

   // The success flag is the same for every result of one item
   a_success_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> (rsp_valid && $stable(rsp_success)))
      else $error("success changed within one item's results");

endmodule

// ===== tb/greedy_change_dispenser_test.sv =====
// Self-checking testbench for the greedy coin change dispenser: predicts every slot report.
module greedy_change_dispenser_test;
   import gcd_pkg::*;

   localparam int SLOTS = 4;

   // Denomination register indexes
   typedef enum logic [1:0] {DENOM_0, DENOM_1, DENOM_2, DENOM_3} denom_reg_type;

   // One expected result item: the state of one slot after a request
   typedef struct packed {
      logic [SLOT_FW-1:0] slot;
      logic [COUNT_W-1:0] used;
      logic [COUNT_W-1:0] stock;
      logic               success;
      logic               last;
   } slot_report_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_type;
   logic [SLOT_FW-1:0]   req_slot;
   logic [COUNT_W-1:0]   req_refill_count;
   logic [DENOM_W-1:0]   req_amount;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [SLOT_FW-1:0]   rsp_out_slot;
   logic [COUNT_W-1:0]   rsp_coins_used;
   logic [COUNT_W-1:0]   rsp_stock_left;
   logic                 rsp_success;
   logic                 rsp_last;
   logic                 csr_we;
   logic [1:0]           csr_index;
   logic [DENOM_W-1:0]   csr_wdata;

   // Shadow of the block's denominations and coin stock
   logic [DENOM_W-1:0]   denom_model [SLOTS];
   logic [COUNT_W-1:0]   stock_model [SLOTS];
   slot_report_type      slot_reports_due [$];
   slot_report_type      report_want;

   int                   mismatches = 0;
   int                   reports_checked = 0;
   int                   refills_sent = 0;
   int                   payouts_made = 0;
   int                   payouts_short = 0;
   int                   cycle_count = 0;
   int                   cycle_budget = 20000;
   bit                   steady = 1'b0;    // no idling on either side
   int                   rsp_wait = 0;     // receiver gap before the next result
   int                   hold_order = 0;   // long receiver hold-off, in cycles
   int                   hold_left = 0;

   greedy_change_dispenser #(.DENOM_SLOTS(SLOTS)) dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog; the budget grows with every item accepted
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > cycle_budget) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("[greedy_change_dispenser] ERROR");
         $finish;
      end
   end

   // Receiver: random gaps per result, plus an optional long hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (hold_order > 0) begin
            hold_left = hold_order;
            hold_order = 0;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait = rsp_wait - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Compare each accepted result item with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (slot_reports_due.size() == 0) begin
            $display("%0t: unexpected result item, slot %0d expected none", $time, rsp_out_slot);
            mismatches++;
         end else begin
            report_want = slot_reports_due.pop_front();
            check_field("out_slot", report_want.slot, rsp_out_slot);
            check_field("coins_used", report_want.used, rsp_coins_used);
            check_field("stock_left", report_want.stock, rsp_stock_left);
            check_field("success", report_want.success, rsp_success);
            check_field("last", report_want.last, rsp_last);
            reports_checked++;
         end
         rsp_wait = steady ? 0 : $urandom_range(0, 5);
      end
   end

   // Apply one request to the shadow stock, queue its slot reports, return coins taken
   function automatic int settle_request(logic kind, logic [SLOT_FW-1:0] slot,
                                         logic [COUNT_W-1:0] count,
                                         logic [DENOM_W-1:0] amount);
      logic [COUNT_W-1:0] used [SLOTS];
      logic [DENOM_W-1:0] left;
      logic [DENOM_W-1:0] best;
      logic               paid;
      int                 pick;
      int                 coins;
      int                 i;
      slot_report_type    r;
      coins = 0;
      paid = 1'b1;
      for (i = 0; i < SLOTS; i++) used[i] = '0;
      if (kind == REQ_REFILL) begin
         if (slot < SLOTS) stock_model[slot] = count;
         refills_sent++;
      end else begin
         // greedy: largest fitting coin in stock, lowest slot on a tie
         left = amount;
         do begin
            pick = -1;
            best = '0;
            for (i = 0; i < SLOTS; i++) begin
               if (denom_model[i] > best && denom_model[i] <= left && stock_model[i] != 0) begin
                  pick = i;
                  best = denom_model[i];
               end
            end
            if (pick >= 0) begin
               stock_model[pick] = stock_model[pick] - 1'b1;
               used[pick] = used[pick] + 1'b1;
               left = left - best;
               coins++;
            end
         end while (pick >= 0 && left != 0);
         paid = (pick >= 0);
         if (paid) payouts_made++;
         else payouts_short++;
      end
      for (i = 0; i < SLOTS; i++) begin
         r.slot = i[SLOT_FW-1:0];
         r.used = used[i];
         r.stock = stock_model[i];
         r.success = paid;
         r.last = (i == SLOTS - 1);
         slot_reports_due.push_back(r);
      end
      return coins;
   endfunction

   // Offer one item after a random gap and wait for it to be taken
   task automatic send_item(logic kind, logic [SLOT_FW-1:0] slot,
                            logic [COUNT_W-1:0] count, logic [DENOM_W-1:0] amount);
      int gap;
      int coins;
      gap = steady ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_slot <= slot;
      req_refill_count <= count;
      req_amount <= amount;
      do @(posedge clock); while (!req_ready);
      coins = settle_request(kind, slot, count, amount);
      cycle_budget = cycle_budget + 4 * (coins + 40);
   endtask

   task automatic refill(logic [SLOT_FW-1:0] slot, logic [COUNT_W-1:0] count);
      send_item(REQ_REFILL, slot, count, DENOM_W'($urandom));
   endtask

   task automatic pay(logic [DENOM_W-1:0] amount);
      send_item(REQ_CHANGE, SLOT_FW'($urandom), COUNT_W'($urandom), amount);
   endtask

   // Stop offering and wait for every expected result item
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (slot_reports_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Rewrite all four denominations while the block is idle
   task automatic set_denoms(logic [DENOM_W-1:0] d0, logic [DENOM_W-1:0] d1,
                             logic [DENOM_W-1:0] d2, logic [DENOM_W-1:0] d3);
      logic [DENOM_W-1:0] vals [SLOTS];
      int i;
      vals = '{d0, d1, d2, d3};
      drain_results();
      for (i = 0; i < SLOTS; i++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_index <= denom_reg_type'(i);
         csr_wdata <= vals[i];
         denom_model[i] = vals[i];
      end
      @(negedge clock);
      csr_we <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   // Amount: mostly sums of current coins, some small, some full range
   function automatic logic [DENOM_W-1:0] pick_amount();
      logic [DENOM_W-1:0] a;
      int n;
      int k;
      case ($urandom_range(0, 15))
         0:       a = '0;
         1, 2:    a = DENOM_W'($urandom);
         3, 4, 5: a = DENOM_W'($urandom_range(1, 60));
         default: begin
            a = '0;
            n = $urandom_range(1, 5);
            for (k = 0; k < n; k++) a = a + denom_model[$urandom_range(0, SLOTS - 1)];
            if ($urandom_range(0, 7) == 0) a = a + 1'b1;
         end
      endcase
      return a;
   endfunction

   task automatic random_item();
      if ($urandom_range(0, 99) < 35)
         refill(SLOT_FW'($urandom_range(0, SLOTS - 1)),
                ($urandom_range(0, 31) == 0) ? COUNT_W'($urandom)
                                             : COUNT_W'($urandom_range(0, 12)));
      else
         pay(pick_amount());
   endtask

   // Empty stock, exact payouts, zero amount, shortfall, wide counts and amounts
   task automatic test_directed_payouts();
      pay(16'd0);
      pay(16'd13);
      refill(2'd0, 16'd3);
      refill(2'd1, 16'd4);
      refill(2'd2, 16'd2);
      refill(2'd3, 16'd1);
      pay(16'd18);
      pay(16'd0);
      pay(16'd4);
      pay(16'd30);
      refill(2'd3, 16'hFFFF);
      refill(2'd0, 16'd0);
      pay(16'hFFFF);
      refill(2'd2, 16'hAAAA);
      refill(2'd1, 16'h5555);
      pay(16'h8000);
   endtask

   // Largest and zero denominations; ties go to the lowest slot
   task automatic test_denom_extremes();
      set_denoms(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
      refill(2'd0, 16'd2);
      refill(2'd1, 16'd1);
      pay(16'hFFFF);
      pay(16'hFFFF);
      pay(16'hFFFF);
      pay(16'hFFFF);
      pay(16'd1);
      set_denoms(16'd0, 16'd0, 16'd0, 16'd0);
      refill(2'd2, 16'd5);
      pay(16'd5);
   endtask

   // Random traffic under several denomination settings
   task automatic test_random_phases();
      int phase;
      int n;
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_denoms(DENOM_RESET[0], DENOM_RESET[1], DENOM_RESET[2], DENOM_RESET[3]);
            1: set_denoms(16'd25, 16'd10, 16'd10, 16'd1);
            2: set_denoms(16'd0, 16'd3, 16'd0, 16'd7);
            3: set_denoms(DENOM_W'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 200)),
                          DENOM_W'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 200)),
                          DENOM_W'($urandom_range(1, 200)),
                          DENOM_W'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 200)));
            default: set_denoms(16'hFFFF, 16'd1, 16'h8000, 16'd2);
         endcase
         for (n = 0; n < 60; n++) random_item();
      end
   endtask

   // Receiver holds off while the sender keeps offering, then the sender waits out all results
   task automatic test_backpressure();
      int n;
      drain_results();
      steady = 1'b1;
      hold_order = 150;
      for (n = 0; n < 8; n++) random_item();
      steady = 1'b0;
      drain_results();
      for (n = 0; n < 4; n++) random_item();
   endtask

   // Back-to-back items with no idling on either side
   task automatic test_back_to_back();
      int n;
      set_denoms(16'd1, 16'd5, 16'd20, 16'd50);
      steady = 1'b1;
      for (n = 0; n < 40; n++) random_item();
      steady = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_REFILL;
      req_slot = '0;
      req_refill_count = '0;
      req_amount = '0;
      csr_we = 1'b0;
      csr_index = DENOM_0;
      csr_wdata = '0;
      denom_model = DENOM_RESET;
      foreach (stock_model[i]) stock_model[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_payouts();
      test_denom_extremes();
      test_random_phases();
      test_backpressure();
      test_back_to_back();

      drain_results();
      repeat (20) @(posedge clock);
      $display("Covered %0d refills and %0d change requests (%0d paid exactly, %0d short),",
               refills_sent, payouts_made + payouts_short, payouts_made, payouts_short);
      $display("%0d slot reports checked across eight denomination settings.", reports_checked);
      if (mismatches == 0 && slot_reports_due.size() == 0) begin
         $display("[greedy_change_dispenser] OK");
      end else begin
         $display("[greedy_change_dispenser] ERROR");
      end
      $finish;
   end

endmodule
